FILE: rtl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types, constants and the mix row function for the string hash.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_BYTES = 12;
    localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
    localparam int MIX_ROWS    = 9;
    localparam int ROW_W       = $clog2(MIX_ROWS);

    localparam logic [WORD_W-1:0] INIT_A = 32'h0000_0000;
    localparam logic [WORD_W-1:0] INIT_B = 32'hDEAD_BEAD;
    localparam logic [WORD_W-1:0] INIT_C = 32'hCAFE_B00B;

    // Where the final add takes its a/b/c from
    localparam int SRC_W = 2;
    localparam logic [SRC_W-1:0] SRC_INIT  = 2'd0;  // no block mixed in this string
    localparam logic [SRC_W-1:0] SRC_CHAIN = 2'd1;  // chaining register
    localparam logic [SRC_W-1:0] SRC_OWN   = 2'd2;  // block mixed by this same job

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } words_t;

    // Side information that travels with a job through the block mixer
    typedef struct packed {
        logic              is_block;
        logic              is_final;
        logic [SRC_W-1:0]  sel;
        logic [WORD_W-1:0] fa;
        logic [WORD_W-1:0] fb;
        logic [WORD_W-1:0] fc;     // tail word for c plus total length
    } job_tag_t;

    localparam words_t INIT_WORDS = '{a: INIT_A, b: INIT_B, c: INIT_C};

    // One row of the mix. Row 3 is the odd one: a-=b; b-=a; a^=c>>12.
    function automatic words_t mix_row(input logic [ROW_W-1:0] row, input words_t w);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        words_t            r;
        begin
            a = w.a;
            b = w.b;
            c = w.c;
            case (row)
                4'd0: a = (a - b - c) ^ (c >> 13);
                4'd1: b = (b - c - a) ^ (a << 8);
                4'd2: c = (c - a - b) ^ (b >> 13);
                4'd3:
                begin
                    a = a - b;
                    b = b - a;
                    a = a ^ (c >> 12);
                end
                4'd4: b = (b - c - a) ^ (a << 16);
                4'd5: c = (c - a - b) ^ (b >> 5);
                4'd6: a = (a - b - c) ^ (c >> 3);
                4'd7: b = (b - c - a) ^ (a << 10);
                4'd8: c = (c - a - b) ^ (b >> 15);
                default: ;
            endcase
            r.a = a;
            r.b = b;
            r.c = c;
            return r;
        end
    endfunction

endpackage

FILE: rtl/lsh_gather.sv
// ----------------------------------------------------------------------------
// lsh_gather
// Byte collection: block buffer, fill and length counts, job register.
// ----------------------------------------------------------------------------
module lsh_gather
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  item_valid,
    input  logic [7:0]                            data_byte,
    input  logic                                  has_byte,
    input  logic                                  last,
    input  lsh_pkg::words_t                       chain,
    output logic                                  job_valid,
    output lsh_pkg::words_t                       job_abc,
    output lsh_pkg::job_tag_t                     job_tag
);

    logic [7:0]                      blk_reg [lsh_pkg::BLOCK_BYTES];
    logic [7:0]                      cur     [lsh_pkg::BLOCK_BYTES];
    logic [7:0]                      tb      [lsh_pkg::BLOCK_BYTES-1];
    logic [lsh_pkg::FILL_W-1:0]      fill_reg;
    logic [lsh_pkg::FILL_W-1:0]      fill_next;
    logic [lsh_pkg::FILL_W-1:0]      cnt;
    logic [lsh_pkg::FILL_W-1:0]      tail_cnt;
    logic [lsh_pkg::WORD_W-1:0]      len_reg;
    logic [lsh_pkg::WORD_W-1:0]      len_next;
    logic [lsh_pkg::WORD_W-1:0]      len_inc;
    logic                            seen_reg;
    logic                            seen_next;
    logic                            accept;
    logic                            block_done;
    lsh_pkg::words_t                 base;
    lsh_pkg::words_t                 abc_next;
    lsh_pkg::job_tag_t               tag_next;
    logic                            job_valid_reg;
    logic                            job_valid_next;
    lsh_pkg::words_t                 job_abc_reg;
    lsh_pkg::job_tag_t               job_tag_reg;

    assign accept = item_valid && adv;

    always_comb
    begin
        for (int i = 0; i < lsh_pkg::BLOCK_BYTES; i++)
        begin
            cur[i] = (has_byte && fill_reg == lsh_pkg::FILL_W'(i)) ? data_byte : blk_reg[i];
        end
        block_done = has_byte && (fill_reg == lsh_pkg::FILL_W'(lsh_pkg::BLOCK_BYTES - 1));
        cnt        = fill_reg + lsh_pkg::FILL_W'(has_byte);
        tail_cnt   = block_done ? '0 : cnt;
        for (int i = 0; i < lsh_pkg::BLOCK_BYTES - 1; i++)
        begin
            tb[i] = (lsh_pkg::FILL_W'(i) < tail_cnt) ? cur[i] : 8'h00;
        end
        len_inc = len_reg + lsh_pkg::WORD_W'(has_byte);

        // block add onto chain (or the start values for a string's first block)
        base       = seen_reg ? chain : lsh_pkg::INIT_WORDS;
        abc_next.a = base.a + {cur[3], cur[2], cur[1], cur[0]};
        abc_next.b = base.b + {cur[7], cur[6], cur[5], cur[4]};
        abc_next.c = base.c + {cur[11], cur[10], cur[9], cur[8]};

        tag_next.is_block = block_done;
        tag_next.is_final = last;
        if (block_done)
            tag_next.sel = lsh_pkg::SRC_OWN;
        else if (seen_reg)
            tag_next.sel = lsh_pkg::SRC_CHAIN;
        else
            tag_next.sel = lsh_pkg::SRC_INIT;
        tag_next.fa = {tb[3], tb[2], tb[1], tb[0]};
        tag_next.fb = {tb[7], tb[6], tb[5], tb[4]};
        tag_next.fc = {tb[10], tb[9], tb[8], 8'h00} + len_inc;

        job_valid_next = accept && (block_done || last);

        fill_next = fill_reg;
        len_next  = len_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (last)
            begin
                fill_next = '0;
                len_next  = '0;
                seen_next = 1'b0;
            end
            else
            begin
                fill_next = block_done ? '0 : cnt;
                len_next  = len_inc;
                seen_next = seen_reg || block_done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            len_reg       <= '0;
            seen_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            len_reg  <= len_next;
            seen_reg <= seen_next;
            if (adv)
                job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_byte)
            blk_reg[fill_reg] <= data_byte;
        if (adv)
        begin
            job_abc_reg <= abc_next;
            job_tag_reg <= tag_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job_abc   = job_abc_reg;
    assign job_tag   = job_tag_reg;

endmodule

FILE: rtl/lsh_mixer.sv
// ----------------------------------------------------------------------------
// lsh_mixer
// Nine-stage mix pipeline, one mix row per stage, with a side tag per stage.
// ----------------------------------------------------------------------------
module lsh_mixer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  lsh_pkg::words_t     in_abc,
    input  lsh_pkg::job_tag_t   in_tag,
    output logic                out_valid,
    output lsh_pkg::words_t     out_abc,
    output lsh_pkg::job_tag_t   out_tag
);

    logic              vld_reg  [lsh_pkg::MIX_ROWS];
    lsh_pkg::words_t   abc_reg  [lsh_pkg::MIX_ROWS];
    lsh_pkg::words_t   abc_next [lsh_pkg::MIX_ROWS];
    lsh_pkg::job_tag_t tag_reg  [lsh_pkg::MIX_ROWS];

    assign abc_next[0] = lsh_pkg::mix_row(lsh_pkg::ROW_W'(0), in_abc);

    for (genvar k = 1; k < lsh_pkg::MIX_ROWS; k++)
    begin : g_row
        assign abc_next[k] = lsh_pkg::mix_row(lsh_pkg::ROW_W'(k), abc_reg[k-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < lsh_pkg::MIX_ROWS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < lsh_pkg::MIX_ROWS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= in_tag;
            for (int k = 0; k < lsh_pkg::MIX_ROWS; k++)
            begin
                abc_reg[k] <= abc_next[k];
            end
            for (int k = 1; k < lsh_pkg::MIX_ROWS; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[lsh_pkg::MIX_ROWS-1];
    assign out_abc   = abc_reg[lsh_pkg::MIX_ROWS-1];
    assign out_tag   = tag_reg[lsh_pkg::MIX_ROWS-1];

endmodule

FILE: rtl/lookup2_string_hash.sv
// ----------------------------------------------------------------------------
// lookup2_string_hash
// Streaming 32-bit string hash, one byte per request, lookup2-style mixing.
//
// Each request carries at most one byte of a string; last closes the string
// and then a single hash_value comes out: hash_valid rises once the closing
// request has passed every stage of the pipeline below, if the output side
// does not stall. The block takes one request every cycle while item_stall
// is low, with no gaps between strings or bytes. A request with has_byte
// low and last low is ignored; has_byte low with last high closes the string
// as it stands (an empty string if nothing came before). Work is a straight
// pipeline: a job register behind the byte buffer, a nine-stage block mixer
// (one mix row per stage), a finalize stage adding length and tail bytes, a
// second nine-stage mixer, and the output register. Each full 12-byte block
// is mixed in the first mixer and its result returns to the chaining register
// before the string's next job can need it. Only when a finished hash sits in
// the output register under hash_stall and another one has reached the end
// of the second mixer does the pipeline hold and item_stall rise.
// ----------------------------------------------------------------------------
module lookup2_string_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [31:0] hash_value
);

    logic              adv;

    logic              job_valid;
    lsh_pkg::words_t   job_abc;
    lsh_pkg::job_tag_t job_tag;

    logic              m1_valid;
    lsh_pkg::words_t   m1_abc;
    lsh_pkg::job_tag_t m1_tag;

    lsh_pkg::words_t   chain_reg;
    lsh_pkg::words_t   src;
    lsh_pkg::words_t   fin_next;

    logic              f_valid_reg;
    lsh_pkg::words_t   f_abc_reg;
    lsh_pkg::job_tag_t f_tag_reg;

    logic              m2_valid;
    lsh_pkg::words_t   m2_abc;
    lsh_pkg::job_tag_t m2_tag;
    logic              m2_hash;

    logic              hash_valid_reg;
    logic [31:0]       hash_value_reg;

    // Hold everything only when a second hash would collide with a stalled one
    assign m2_hash    = m2_valid && m2_tag.is_final;
    assign adv        = !(hash_valid_reg && hash_stall && m2_hash);
    assign item_stall = !adv;

    lsh_gather u_gather
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (item_valid),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last       (last),
        .chain      (chain_reg),
        .job_valid  (job_valid),
        .job_abc    (job_abc),
        .job_tag    (job_tag)
    );

    // Block mixer
    lsh_mixer u_mix_blk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (job_valid),
        .in_abc    (job_abc),
        .in_tag    (job_tag),
        .out_valid (m1_valid),
        .out_abc   (m1_abc),
        .out_tag   (m1_tag)
    );

    // Finalize: pick chaining source, add tail words and length
    always_comb
    begin
        case (m1_tag.sel)
            lsh_pkg::SRC_OWN:   src = m1_abc;
            lsh_pkg::SRC_CHAIN: src = chain_reg;
            default:            src = lsh_pkg::INIT_WORDS;
        endcase
        fin_next.a = src.a + m1_tag.fa;
        fin_next.b = src.b + m1_tag.fb;
        fin_next.c = src.c + m1_tag.fc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (adv)
            f_valid_reg <= m1_valid && m1_tag.is_final;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_abc_reg <= fin_next;
            f_tag_reg <= m1_tag;
            if (m1_valid && m1_tag.is_block)
                chain_reg <= m1_abc;
        end
    end

    // Final mixer
    lsh_mixer u_mix_fin
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid_reg),
        .in_abc    (f_abc_reg),
        .in_tag    (f_tag_reg),
        .out_valid (m2_valid),
        .out_abc   (m2_abc),
        .out_tag   (m2_tag)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_valid_reg <= 1'b0;
        else if (adv && m2_hash)
            hash_valid_reg <= 1'b1;
        else if (!hash_stall)
            hash_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && m2_hash)
            hash_value_reg <= m2_abc.c;
    end

    assign hash_valid = hash_valid_reg;
    assign hash_value = hash_value_reg;

endmodule
